// ===== sv/rv32d_pkg.sv =====
`default_nettype none
package rv32d_pkg;

    // field widths
    localparam int unsigned XlenW    = 32;
    localparam int unsigned RegIdxW  = 5;
    localparam int unsigned UseW     = 4;
    localparam int unsigned UnitW    = 2;
    localparam int unsigned AluW     = 3;
    localparam int unsigned AccW     = 3;
    localparam int unsigned FmtW     = 3;

    // stream widths
    localparam int unsigned InDataW  = 64;
    localparam int unsigned OutDataW = 128;

    // major opcodes
    localparam logic [6:0] OpcodeMask   = 7'h7F;
    localparam logic [6:0] OpcLui       = 7'h37;
    localparam logic [6:0] OpcJal       = 7'h6F;
    localparam logic [6:0] OpcOpImm     = 7'h13;
    localparam logic [6:0] OpcOp        = 7'h33;
    localparam logic [6:0] OpcLoad      = 7'h03;
    localparam logic [6:0] OpcStore     = 7'h23;
    localparam logic [6:0] OpcBranch    = 7'h63;
    localparam logic [6:0] OpcJalr      = 7'h67;

    // funct7 that selects sub / arithmetic shift
    localparam logic [6:0] Funct7Alt    = 7'h20;

    // funct3 codes of interest
    localparam logic [2:0] F3AddSub     = 3'd0;
    localparam logic [2:0] F3Half       = 3'd1;
    localparam logic [2:0] F3Sltu       = 3'd3;
    localparam logic [2:0] F3ByteU      = 3'd4;
    localparam logic [2:0] F3Shr        = 3'd5;
    localparam logic [2:0] F3Or         = 3'd6;
    localparam logic [2:0] F3And        = 3'd7;

    // operand use bits
    localparam int unsigned UseDest = 0;
    localparam int unsigned UseSrc1 = 1;
    localparam int unsigned UseSrc2 = 2;
    localparam int unsigned UseImm  = 3;

    // functional units
    localparam logic [UnitW-1:0] UnitAlu    = 2'd0;
    localparam logic [UnitW-1:0] UnitLsu    = 2'd1;
    localparam logic [UnitW-1:0] UnitBranch = 2'd2;

    // alu operations
    localparam logic [AluW-1:0] AluAdd   = 3'd0;
    localparam logic [AluW-1:0] AluSub   = 3'd1;
    localparam logic [AluW-1:0] AluAnd   = 3'd2;
    localparam logic [AluW-1:0] AluOr    = 3'd3;
    localparam logic [AluW-1:0] AluSrl   = 3'd4;
    localparam logic [AluW-1:0] AluSra   = 3'd5;
    localparam logic [AluW-1:0] AluSltiu = 3'd6;
    localparam logic [AluW-1:0] AluLui   = 3'd7;

    // access kinds
    localparam logic [AccW-1:0] AccNone   = 3'd0;
    localparam logic [AccW-1:0] AccLoad   = 3'd1;
    localparam logic [AccW-1:0] AccStore  = 3'd2;
    localparam logic [AccW-1:0] AccBranch = 3'd3;
    localparam logic [AccW-1:0] AccJump   = 3'd4;

    // memory formats: size in bits 1:0, unsigned flag in bit 2
    localparam logic [FmtW-1:0] FmtByteU = 3'b100;
    localparam logic [FmtW-1:0] FmtHalf  = 3'b001;
    localparam logic [FmtW-1:0] FmtWord  = 3'b010;

    typedef struct packed {
        logic                    valid;
        logic [XlenW-1:0]        pc;
        logic [XlenW-1:0]        instruction;
        logic [RegIdxW-1:0]      dest_reg;
        logic [RegIdxW-1:0]      src1_reg;
        logic [RegIdxW-1:0]      src2_reg;
        logic [UseW-1:0]         operand_use;
        logic [UnitW-1:0]        unit_kind;
        logic [AluW-1:0]         alu_operation;
        logic signed [XlenW-1:0] immediate;
        logic [AccW-1:0]         access_kind;
        logic [FmtW-1:0]         memory_format;
    } packet_t;

endpackage
`default_nettype wire

// ===== sv/rv32_subset_instruction_decoder.sv =====
`default_nettype none
// rv32 subset decoder: takes one beat per cycle on the slave side (instr_valid in s_tuser,
// fetch pc and instruction word in s_tdata) and hands out one decoded packet beat on the
// master side for each beat taken. every beat passes an input register, one level of decode
// logic and a result register, and a new beat can be taken every cycle while the pipeline
// does not stall; throughput is one beat per cycle, set by the two-deep register pipeline,
// which stalls only while m_tready holds a full result register and the input register
// behind it. LUI, JAL, JALR, OP-IMM, OP, LOAD, STORE and BRANCH are decoded;
// any other opcode yields a valid packet with default fields, and an invalid slot yields an
// all-zero packet. OP with funct3 5 decodes as SRA whatever funct7 holds.
module rv32_subset_instruction_decoder
(
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,

    input  wire  logic                           s_tvalid,
    output logic                                 s_tready,
    // [31:0] fetch_pc, [63:32] instruction
    input  wire  logic [rv32d_pkg::InDataW-1:0]  s_tdata,
    // [0] instr_valid
    input  wire  logic                           s_tuser,

    output logic                                 m_tvalid,
    input  wire  logic                           m_tready,
    // [31:0] packet_pc, [63:32] packet_instruction, [68:64] dest_reg, [73:69] src1_reg,
    // [78:74] src2_reg, [82:79] operand_use, [84:83] unit_kind, [87:85] alu_operation,
    // [119:88] immediate, [122:120] access_kind, [125:123] memory_format, [127:126] zero
    output logic [rv32d_pkg::OutDataW-1:0]       m_tdata,
    // [0] packet_valid
    output logic                                 m_tuser
);
    import rv32d_pkg::*;

    // input register stage
    logic               in_full_reg;
    logic               in_slot_valid_reg;
    logic [XlenW-1:0]   in_pc_reg;
    logic [XlenW-1:0]   in_instr_reg;

    // result register stage
    logic               out_full_reg;
    packet_t            out_pkt_reg;
    packet_t            out_pkt_next;

    logic               out_ready;
    logic               in_ready;
    logic               s_beat;
    logic               move_beat;

    // decode fields
    logic [6:0]         opcode;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic [XlenW-1:0]   imm_i;
    logic [XlenW-1:0]   imm_s;
    logic [XlenW-1:0]   imm_b;
    logic [XlenW-1:0]   imm_u;
    logic [XlenW-1:0]   imm_j;
    logic               writes_dest;

    // pipeline control: each stage frees up as soon as the one after it moves
    assign out_ready = !out_full_reg || m_tready;
    assign in_ready  = !in_full_reg || out_ready;
    assign s_tready  = in_ready;
    assign s_beat    = s_tvalid && in_ready;
    assign move_beat = in_full_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= s_tvalid;
            end
            if (out_ready)
            begin
                out_full_reg <= in_full_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_slot_valid_reg <= s_tuser;
            in_pc_reg         <= s_tdata[XlenW-1:0];
            in_instr_reg      <= s_tdata[2*XlenW-1:XlenW];
        end
        if (move_beat)
        begin
            out_pkt_reg <= out_pkt_next;
        end
    end

    // instruction fields
    assign opcode = in_instr_reg[6:0] & OpcodeMask;
    assign f3     = in_instr_reg[14:12];
    assign f7     = in_instr_reg[31:25];

    // immediate forms, sign taken from bit 31
    assign imm_i = {{21{in_instr_reg[31]}}, in_instr_reg[30:20]};
    assign imm_s = {{21{in_instr_reg[31]}}, in_instr_reg[30:25], in_instr_reg[11:7]};
    assign imm_b = {{20{in_instr_reg[31]}}, in_instr_reg[7], in_instr_reg[30:25],
                    in_instr_reg[11:8], 1'b0};
    assign imm_u = {in_instr_reg[31:12], 12'b0};
    assign imm_j = {{12{in_instr_reg[31]}}, in_instr_reg[19:12], in_instr_reg[20],
                    in_instr_reg[30:21], 1'b0};

    always_comb
    begin
        out_pkt_next               = '0;
        writes_dest                = 1'b0;
        out_pkt_next.valid         = 1'b1;
        out_pkt_next.pc            = in_pc_reg;
        out_pkt_next.instruction   = in_instr_reg;
        out_pkt_next.dest_reg      = in_instr_reg[11:7];
        out_pkt_next.src1_reg      = in_instr_reg[19:15];
        out_pkt_next.src2_reg      = in_instr_reg[24:20];
        out_pkt_next.unit_kind     = UnitAlu;
        out_pkt_next.alu_operation = AluAdd;
        out_pkt_next.access_kind   = AccNone;
        out_pkt_next.memory_format = FmtWord;

        case (opcode)
            OpcLui:
            begin
                writes_dest                      = 1'b1;
                out_pkt_next.alu_operation       = AluLui;
                out_pkt_next.operand_use[UseImm] = 1'b1;
                out_pkt_next.immediate           = imm_u;
            end
            OpcJal:
            begin
                writes_dest                      = 1'b1;
                out_pkt_next.unit_kind           = UnitBranch;
                out_pkt_next.access_kind         = AccJump;
                out_pkt_next.operand_use[UseImm] = 1'b1;
                out_pkt_next.immediate           = imm_j;
            end
            OpcOpImm:
            begin
                writes_dest                       = 1'b1;
                out_pkt_next.operand_use[UseSrc1] = 1'b1;
                out_pkt_next.operand_use[UseImm]  = 1'b1;
                out_pkt_next.immediate            = imm_i;
                case (f3)
                    F3Or:    out_pkt_next.alu_operation = AluOr;
                    F3And:   out_pkt_next.alu_operation = AluAnd;
                    F3Sltu:  out_pkt_next.alu_operation = AluSltiu;
                    F3Shr:   out_pkt_next.alu_operation = (f7 == Funct7Alt) ? AluSra : AluSrl;
                    default: out_pkt_next.alu_operation = AluAdd;
                endcase
            end
            OpcOp:
            begin
                writes_dest                       = 1'b1;
                out_pkt_next.operand_use[UseSrc1] = 1'b1;
                out_pkt_next.operand_use[UseSrc2] = 1'b1;
                case (f3)
                    F3AddSub: out_pkt_next.alu_operation = (f7 == Funct7Alt) ? AluSub : AluAdd;
                    F3And:    out_pkt_next.alu_operation = AluAnd;
                    F3Or:     out_pkt_next.alu_operation = AluOr;
                    F3Shr:    out_pkt_next.alu_operation = AluSra;
                    default:  out_pkt_next.alu_operation = AluAdd;
                endcase
            end
            OpcLoad:
            begin
                writes_dest                       = 1'b1;
                out_pkt_next.unit_kind            = UnitLsu;
                out_pkt_next.access_kind          = AccLoad;
                out_pkt_next.operand_use[UseSrc1] = 1'b1;
                out_pkt_next.operand_use[UseImm]  = 1'b1;
                out_pkt_next.immediate            = imm_i;
                if (f3 == F3ByteU)
                begin
                    out_pkt_next.memory_format = FmtByteU;
                end
            end
            OpcStore:
            begin
                out_pkt_next.unit_kind            = UnitLsu;
                out_pkt_next.access_kind          = AccStore;
                out_pkt_next.operand_use[UseSrc1] = 1'b1;
                out_pkt_next.operand_use[UseSrc2] = 1'b1;
                out_pkt_next.operand_use[UseImm]  = 1'b1;
                out_pkt_next.immediate            = imm_s;
                if (f3 == F3Half)
                begin
                    out_pkt_next.memory_format = FmtHalf;
                end
            end
            OpcBranch:
            begin
                out_pkt_next.unit_kind            = UnitBranch;
                out_pkt_next.access_kind          = AccBranch;
                out_pkt_next.operand_use[UseSrc1] = 1'b1;
                out_pkt_next.operand_use[UseSrc2] = 1'b1;
                out_pkt_next.operand_use[UseImm]  = 1'b1;
                out_pkt_next.immediate            = imm_b;
            end
            OpcJalr:
            begin
                writes_dest                       = 1'b1;
                out_pkt_next.unit_kind            = UnitBranch;
                out_pkt_next.access_kind          = AccJump;
                out_pkt_next.operand_use[UseSrc1] = 1'b1;
                out_pkt_next.operand_use[UseImm]  = 1'b1;
                out_pkt_next.immediate            = imm_i;
            end
            default:
            begin
                // unknown opcode keeps the defaults above
                writes_dest = 1'b0;
            end
        endcase

        // x0 as destination is never a real write
        out_pkt_next.operand_use[UseDest] = writes_dest && (in_instr_reg[11:7] != '0);

        // an empty slot gives an all-zero packet
        if (!in_slot_valid_reg)
        begin
            out_pkt_next = '0;
        end
    end

    // output packing, lowest field first
    assign m_tvalid = out_full_reg;
    assign m_tuser  = out_pkt_reg.valid;
    assign m_tdata  = {2'b00,
                       out_pkt_reg.memory_format,
                       out_pkt_reg.access_kind,
                       out_pkt_reg.immediate,
                       out_pkt_reg.alu_operation,
                       out_pkt_reg.unit_kind,
                       out_pkt_reg.operand_use,
                       out_pkt_reg.src2_reg,
                       out_pkt_reg.src1_reg,
                       out_pkt_reg.dest_reg,
                       out_pkt_reg.instruction,
                       out_pkt_reg.pc};

    // an empty-slot packet carries nothing
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid packet with nonzero payload");

    // x0 destination never flagged as used
    a_x0_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_pkt_reg.dest_reg == '0)) |-> !out_pkt_reg.operand_use[UseDest])
        else $error("x0 destination flagged as used");

    // memory accesses go to the load/store unit, control transfers to the branch unit
    a_unit_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (((out_pkt_reg.access_kind == AccLoad) || (out_pkt_reg.access_kind == AccStore))
                == (out_pkt_reg.unit_kind == UnitLsu)) &&
            (((out_pkt_reg.access_kind == AccBranch) || (out_pkt_reg.access_kind == AccJump))
                == (out_pkt_reg.unit_kind == UnitBranch)))
        else $error("unit kind does not match access kind");

    // a stalled result must not be overwritten
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_pkt_reg)))
        else $error("stalled result changed");

    // a beat taken into an empty pipe shows up at the output after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !in_full_reg && !out_full_reg) |=> ##1 m_tvalid)
        else $error("beat lost in pipeline");

endmodule
`default_nettype wire
